### rtl/rational_accumulator_alu_defines.svh
// Assertion macros shared by the checker of the rational accumulator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RATIONAL_ACCUMULATOR_ALU_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RAA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rat_pkg.sv
// Shared types, codes and helper functions of the rational accumulator.
// No dependencies; imported by every module of the block.
package rat_pkg;

   localparam int W  = 32;
   localparam int KW = $clog2(W + 1);

   typedef logic [W-1:0] word_type;

   localparam word_type ONE = word_type'(1);

   localparam logic [2:0] CMD_LOAD = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;
   localparam logic [2:0] CMD_ABS  = 3'd5;
   localparam logic [2:0] CMD_SGN  = 3'd6;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quotient;
   } div_rsp_type;

   // magnitude of a two's complement word (most negative maps to itself)
   function automatic word_type mag(word_type v);
      return v[W-1] ? (~v + ONE) : v;
   endfunction

   function automatic word_type sgn_apply(logic neg, word_type m);
      return neg ? (~m + ONE) : m;
   endfunction

   // magnitude does not fit the signed range for the given sign
   function automatic logic ms_ovf(logic neg, word_type m);
      return neg ? (m[W-1] && (m[W-2:0] != '0)) : m[W-1];
   endfunction

endpackage

### rtl/rat_div.sv
// One-bit-per-cycle restoring divider for unsigned words.
// Depends on rat_pkg.
module rat_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rat_pkg::div_req_type req,
   output rat_pkg::div_rsp_type rsp
);
   import rat_pkg::*;

   word_type      rem_ff, rem_in;
   word_type      quo_ff, quo_in;
   word_type      dvs_ff, dvs_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = KW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
         end
         quo_in = {quo_ff[W-2:0], !trial[W]};
         cnt_in = cnt_ff - KW'(1);
         if (cnt_ff == KW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### rtl/rational_accumulator_alu.sv
// Rational accumulator: keeps a signed fraction num/den and applies one command per
// transaction (load, add, subtract, multiply, divide, absolute, sign to numerator),
// always leaving the fraction reduced by the gcd, with a zero numerator giving den 1.
// Each request returns exactly one response carrying the new accumulator and a status
// (ok, zero denominator / division by zero with state kept, or overflow wrapped).
// The block takes one transaction at a time: req_tready is high only while idle, and
// the response waits in its register until rsp_tready. The length of a transaction is
// set by the binary gcd loop (one subtract-shift a cycle) and the restoring divider;
// the gcd pass can run three times per command, each pass followed by two divisions;
// one 32x32 multiplier is reused for all products.
// Depends on rat_pkg and rat_div.
module rational_accumulator_alu (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*rat_pkg::W-1:0]   req_tdata,   // operand_num, operand_den
   input  logic [2:0]                req_tuser,   // command
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2*rat_pkg::W-1:0]   rsp_tdata,   // result_num, result_den
   output logic [1:0]                rsp_tuser    // status
);
   import rat_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_GCD  = 4'd1;
   localparam logic [3:0] S_DIVA = 4'd2;
   localparam logic [3:0] S_DIVB = 4'd3;
   localparam logic [3:0] S_POST = 4'd4;
   localparam logic [3:0] S_DISP = 4'd5;
   localparam logic [3:0] S_M1   = 4'd6;
   localparam logic [3:0] S_M2   = 4'd7;
   localparam logic [3:0] S_M3   = 4'd8;
   localparam logic [3:0] S_SUM  = 4'd9;
   localparam logic [3:0] S_FIN  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   // what the gcd/divide pass is reducing
   localparam logic [1:0] PH_OPRED  = 2'd0;
   localparam logic [1:0] PH_ADDSUB = 2'd1;
   localparam logic [1:0] PH_FINRED = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    ph_ff, ph_in;
   logic [2:0]    cmd_ff, cmd_in;
   word_type      acc_n_ff, acc_n_in, acc_d_ff, acc_d_in;
   word_type      wn_ff, wn_in, wd_ff, wd_in;     // working accumulator
   word_type      rn_ff, rn_in, rd_ff, rd_in;     // working operand
   word_type      ga_ff, ga_in, gb_ff, gb_in;     // binary gcd
   logic [KW-1:0] gk_ff, gk_in;
   word_type      xa_ff, xa_in, xb_ff, xb_in;     // values to divide by the gcd
   word_type      g_ff, g_in;
   word_type      qa_ff, qa_in, qb_ff, qb_in;
   word_type      sm_ff, sm_in, om_ff, om_in;     // add/sub scale factors
   word_type      p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic          ovf_ff, ovf_in;
   logic [1:0]    st_ff, st_in;

   div_req_type   dreq;
   div_rsp_type   drsp;

   // shared multiplier
   word_type      mul_a, mul_b, ma, mb, mul_val;
   logic [2*W-1:0] full;
   logic          mneg, mul_ovf;

   logic [2:0]    req_cmd;
   word_type      req_on, req_od, gres, sum, gdiff;
   logic          is_as, gdone, dz, ovf_now, sum_ovf;

   rat_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign req_cmd = req_tuser;
   assign req_on  = req_tdata[W-1:0];
   assign req_od  = req_tdata[2*W-1:W];
   assign is_as   = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_SUB);
   assign gdone   = (ga_ff == '0) || (gb_ff == '0);
   assign gres    = word_type'((ga_ff | gb_ff) << gk_ff);
   assign gdiff   = (ga_ff >= gb_ff) ? (ga_ff - gb_ff) : (gb_ff - ga_ff);

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_M1: begin
            mul_a = wn_ff;
            mul_b = is_as ? sm_ff : ((cmd_ff == CMD_MUL) ? rn_ff : rd_ff);
         end
         S_M2: begin
            mul_a = is_as ? rn_ff : wd_ff;
            mul_b = is_as ? om_ff : ((cmd_ff == CMD_MUL) ? rd_ff : rn_ff);
         end
         S_M3: begin
            mul_a = qa_ff;
            mul_b = mag(rd_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      ma      = mag(mul_a);
      mb      = mag(mul_b);
      full    = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
      mneg    = mul_a[W-1] ^ mul_b[W-1];
      mul_ovf = (full[2*W-1:W] != '0) || ms_ovf(mneg, full[W-1:0]);
      mul_val = sgn_apply(mneg, full[W-1:0]);
   end

   // add or subtract of the two cross products
   always_comb begin
      if (cmd_ff == CMD_ADD) begin
         sum     = p1_ff + p2_ff;
         sum_ovf = (p1_ff[W-1] == p2_ff[W-1]) && (sum[W-1] != p1_ff[W-1]);
      end else begin
         sum     = p1_ff - p2_ff;
         sum_ovf = (p1_ff[W-1] != p2_ff[W-1]) && (sum[W-1] != p1_ff[W-1]);
      end
   end

   assign dz      = (wd_ff == '0) && (wn_ff != '0);
   assign ovf_now = ovf_ff | dz;

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      cmd_in   = cmd_ff;
      acc_n_in = acc_n_ff;
      acc_d_in = acc_d_ff;
      wn_in    = wn_ff;
      wd_in    = wd_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      ga_in    = ga_ff;
      gb_in    = gb_ff;
      gk_in    = gk_ff;
      xa_in    = xa_ff;
      xb_in    = xb_ff;
      g_in     = g_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      sm_in    = sm_ff;
      om_in    = om_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      ovf_in   = ovf_ff;
      st_in    = st_ff;
      dreq     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_cmd;
               ovf_in = 1'b0;
               wn_in  = acc_n_ff;
               wd_in  = acc_d_ff;
               rn_in  = req_on;
               rd_in  = req_od;
               if (((req_cmd <= CMD_DIV) && (req_od == '0)) ||
                   ((req_cmd == CMD_DIV) && (req_on == '0))) begin
                  st_in    = ST_ZERO;
                  state_in = S_OUT;
               end else if (req_cmd == CMD_ABS) begin
                  wn_in    = mag(acc_n_ff);
                  wd_in    = mag(acc_d_ff);
                  ovf_in   = ms_ovf(1'b0, mag(acc_n_ff)) || ms_ovf(1'b0, mag(acc_d_ff));
                  state_in = S_FIN;
               end else if (req_cmd == CMD_SGN) begin
                  if (acc_d_ff[W-1]) begin
                     wn_in  = ~acc_n_ff + ONE;
                     wd_in  = ~acc_d_ff + ONE;
                     ovf_in = ms_ovf(1'b0, mag(acc_n_ff)) || ms_ovf(1'b0, mag(acc_d_ff));
                  end
                  state_in = S_FIN;
               end else if (req_cmd <= CMD_DIV) begin
                  if (req_on == '0) begin
                     rn_in    = '0;
                     rd_in    = ONE;
                     state_in = S_DISP;
                  end else begin
                     ga_in    = mag(req_on);
                     gb_in    = mag(req_od);
                     xa_in    = mag(req_on);
                     xb_in    = mag(req_od);
                     gk_in    = '0;
                     ph_in    = PH_OPRED;
                     state_in = S_GCD;
                  end
               end else begin
                  // unused command: echo the accumulator
                  st_in    = ST_OK;
                  state_in = S_OUT;
               end
            end
         end

         S_GCD: begin
            if (gdone) begin
               g_in          = gres;
               dreq.start    = 1'b1;
               dreq.dividend = xa_ff;
               dreq.divisor  = gres;
               state_in      = S_DIVA;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + KW'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = gdiff >> 1;
            end else begin
               gb_in = gdiff >> 1;
            end
         end

         S_DIVA: begin
            if (drsp.done) begin
               qa_in         = drsp.quotient;
               dreq.start    = 1'b1;
               dreq.dividend = xb_ff;
               dreq.divisor  = g_ff;
               state_in      = S_DIVB;
            end
         end

         S_DIVB: begin
            if (drsp.done) begin
               qb_in    = drsp.quotient;
               state_in = S_POST;
            end
         end

         S_POST: begin
            unique case (ph_ff)
               PH_OPRED: begin
                  rn_in    = sgn_apply(rn_ff[W-1], qa_ff);
                  rd_in    = sgn_apply(rd_ff[W-1], qb_ff);
                  state_in = S_DISP;
               end
               PH_ADDSUB: begin
                  // qa = |d|/g, qb = |od|/g
                  sm_in    = sgn_apply(wd_ff[W-1], qb_ff);
                  om_in    = sgn_apply(rd_ff[W-1], qa_ff);
                  ovf_in   = ovf_ff || ms_ovf(wd_ff[W-1], qb_ff) ||
                             ms_ovf(rd_ff[W-1], qa_ff);
                  state_in = S_M1;
               end
               default: begin
                  acc_n_in = sgn_apply(wn_ff[W-1], qa_ff);
                  acc_d_in = sgn_apply(wd_ff[W-1], qb_ff);
                  st_in    = ovf_ff ? ST_OVF : ST_OK;
                  state_in = S_OUT;
               end
            endcase
         end

         S_DISP: begin
            priority case (cmd_ff)
               CMD_LOAD: begin
                  wn_in    = rn_ff;
                  wd_in    = rd_ff;
                  state_in = S_FIN;
               end
               CMD_ADD, CMD_SUB: begin
                  if (rn_ff == '0) begin
                     state_in = S_FIN;
                  end else begin
                     ga_in    = mag(wd_ff);
                     gb_in    = mag(rd_ff);
                     xa_in    = mag(wd_ff);
                     xb_in    = mag(rd_ff);
                     gk_in    = '0;
                     ph_in    = PH_ADDSUB;
                     state_in = S_GCD;
                  end
               end
               CMD_MUL: begin
                  if (rn_ff == '0) begin
                     wn_in    = '0;
                     wd_in    = ONE;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_M1;
                  end
               end
               default: begin
                  state_in = S_M1;
               end
            endcase
         end

         S_M1: begin
            p1_in    = mul_val;
            ovf_in   = ovf_ff | mul_ovf;
            state_in = S_M2;
         end

         S_M2: begin
            p2_in    = mul_val;
            ovf_in   = ovf_ff | mul_ovf;
            state_in = is_as ? S_M3 : S_SUM;
         end

         S_M3: begin
            p3_in    = mul_val;
            ovf_in   = ovf_ff | mul_ovf;
            state_in = S_SUM;
         end

         S_SUM: begin
            if (is_as) begin
               wn_in  = sum;
               wd_in  = p3_ff;
               ovf_in = ovf_ff | sum_ovf;
            end else begin
               wn_in = p1_ff;
               wd_in = p2_ff;
            end
            state_in = S_FIN;
         end

         S_FIN: begin
            // wrapped zero denominator counts as overflow; a zero numerator or denominator gives den 1, else reduce
            ovf_in = ovf_now;
            if (wn_ff == '0) begin
               acc_n_in = '0;
               acc_d_in = ONE;
               st_in    = ovf_now ? ST_OVF : ST_OK;
               state_in = S_OUT;
            end else if (wd_ff == '0) begin
               acc_n_in = wn_ff;
               acc_d_in = ONE;
               st_in    = ovf_now ? ST_OVF : ST_OK;
               state_in = S_OUT;
            end else begin
               ga_in    = mag(wn_ff);
               gb_in    = mag(wd_ff);
               xa_in    = mag(wn_ff);
               xb_in    = mag(wd_ff);
               gk_in    = '0;
               ph_in    = PH_FINRED;
               state_in = S_GCD;
            end
         end

         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ph_ff  <= ph_in;
      cmd_ff <= cmd_in;
      wn_ff  <= wn_in;
      wd_ff  <= wd_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      ga_ff  <= ga_in;
      gb_ff  <= gb_in;
      gk_ff  <= gk_in;
      xa_ff  <= xa_in;
      xb_ff  <= xb_in;
      g_ff   <= g_in;
      qa_ff  <= qa_in;
      qb_ff  <= qb_in;
      sm_ff  <= sm_in;
      om_ff  <= om_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      p3_ff  <= p3_in;
      ovf_ff <= ovf_in;
      st_ff  <= st_in;
      if (reset) begin
         state_ff <= S_IDLE;
         acc_n_ff <= '0;
         acc_d_ff <= ONE;
      end else begin
         state_ff <= state_in;
         acc_n_ff <= acc_n_in;
         acc_d_ff <= acc_d_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {acc_d_ff, acc_n_ff};
   assign rsp_tuser  = st_ff;

endmodule

### rtl/rat_chk.sv
// Port-level checker for the rational accumulator, bound to the top level.
// Depends on rat_pkg and rational_accumulator_alu_defines.svh.
`include "rational_accumulator_alu_defines.svh"

module rat_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [2*rat_pkg::W-1:0] req_tdata,
   input logic [2:0]              req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [2*rat_pkg::W-1:0] rsp_tdata,
   input logic [1:0]              rsp_tuser
);
   import rat_pkg::*;

   `RAA_ASSERT_NOW(a_one_at_a_time, clock, reset, rsp_tvalid, !req_tready, "request taken while a response is pending")
   `RAA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after a request transaction")
   `RAA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `RAA_ASSERT_NOW(a_den_nonzero, clock, reset, rsp_tvalid, rsp_tdata[2*W-1:W] != '0, "response denominator is zero")
   `RAA_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tuser != 2'd3, "response status code out of range")

endmodule

bind rational_accumulator_alu rat_chk u_rat_chk (.*);
